>>> rtl/hce_pkg.sv
// shared widths, register indexes and encoding helpers of the hamming encoder
`timescale 1ns / 1ps

package hce_pkg;

  // field widths
  localparam int DATA_W        = 57;
  localparam int CW_W          = 63;
  localparam int PC_W          = 3;
  localparam int LEN_W         = 6;
  localparam int NUM_PAR       = 6;
  localparam int MAX_DATA_BITS = 57;

  // stream widths, padded to whole bytes
  localparam int S_TDATA_W = ((DATA_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((CW_W + PC_W + LEN_W + 7) / 8) * 8;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam logic [CFG_IDX_W-1:0] REG_DATA_LEN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INJECT_EN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INJECT_POS = 2'd2;

  // register reset values
  localparam logic [LEN_W-1:0] DATA_LEN_RST   = 6'd9;
  localparam logic [LEN_W-1:0] INJECT_POS_RST = 6'd1;

  // one result request, codeword in the low bits
  typedef struct packed {
    logic [LEN_W-1:0] codeword_len;
    logic [PC_W-1:0]  parity_count;
    logic [CW_W-1:0]  codeword;
  } result_t;

  // true for position numbers that hold a parity bit
  function automatic bit is_pow2(input int p);
    return (p != 0) && ((p & (p - 1)) == 0);
  endfunction

  // positions covered by parity bit k
  function automatic logic [CW_W-1:0] par_mask(input int k);
    logic [CW_W-1:0] m;
    m = '0;
    for (int p = 1; p <= CW_W; p++) begin
      m[p-1] = ((p >> k) & 1) != 0;
    end
    return m;
  endfunction

  // least r with 2^r >= len + r + 1, for len in 1..57
  function automatic logic [PC_W-1:0] parity_count(input logic [LEN_W-1:0] len);
    logic [PC_W-1:0] r;
    priority if (len <= 6'd1) begin
      r = 3'd2;
    end else if (len <= 6'd4) begin
      r = 3'd3;
    end else if (len <= 6'd11) begin
      r = 3'd4;
    end else if (len <= 6'd26) begin
      r = 3'd5;
    end else begin
      r = 3'd6;
    end
    return r;
  endfunction

endpackage

>>> rtl/hamming_code_encoder_unit.sv
// hamming encoder for variable-length data words, one word per cycle while m_axis does not stall
`timescale 1ns / 1ps

// channel   | direction | payload (lowest bit first)
// s_axis    | in        | tdata: data_word[56:0], zero pad to 64
// m_axis    | out       | tdata: codeword[62:0], parity_count[65:63], codeword_len[71:66]
// cfg       | in        | cfg_idx_i selects data_len, inject_enable, inject_position
//
// one request per cycle sustained while m_axis does not stall; an accepted request reaches m_axis valid
// through an input register that feeds the encode logic, whose result lands in the output register
// reset clears both valid flags and loads data_len 9, injection off, inject_position 1
// a stalled output holds its result; the input register still advances into a free slot

module hamming_code_encoder_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration writes
  input  logic                             cfg_we_i,
  input  logic [hce_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [hce_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  // input stream
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [hce_pkg::S_TDATA_W-1:0]    s_axis_tdata_i,  // data_word
  // output stream
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [hce_pkg::M_TDATA_W-1:0]    m_axis_tdata_o   // codeword, parity_count, codeword_len
);

  // configuration registers
  logic [hce_pkg::LEN_W-1:0] data_len_q;
  logic                      inject_en_q;
  logic [hce_pkg::LEN_W-1:0] inject_pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_len_q   <= hce_pkg::DATA_LEN_RST;
      inject_en_q  <= 1'b0;
      inject_pos_q <= hce_pkg::INJECT_POS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        hce_pkg::REG_DATA_LEN:   data_len_q   <= cfg_wdata_i[hce_pkg::LEN_W-1:0];
        hce_pkg::REG_INJECT_EN:  inject_en_q  <= cfg_wdata_i[0];
        hce_pkg::REG_INJECT_POS: inject_pos_q <= cfg_wdata_i[hce_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline handshake
  logic in_valid_q;
  logic out_valid_q;
  logic out_free;
  logic in_free;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign in_free         = !in_valid_q || out_free;
  assign s_axis_tready_o = in_free;
  assign m_axis_tvalid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_free) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // input data register
  logic [hce_pkg::DATA_W-1:0] data_q;

  always_ff @(posedge clk_i) begin
    if (in_free && s_axis_tvalid_i) begin
      data_q <= s_axis_tdata_i[hce_pkg::DATA_W-1:0];
    end
  end

  // clamp the configured length to 1..MAX_DATA_BITS
  logic [hce_pkg::LEN_W-1:0] len_eff;
  logic [hce_pkg::PC_W-1:0]  par_cnt;
  logic [hce_pkg::LEN_W-1:0] total_len;
  logic [hce_pkg::DATA_W-1:0] data_mask;
  logic [hce_pkg::DATA_W-1:0] data_used;

  always_comb begin
    priority if (data_len_q == '0) begin
      len_eff = hce_pkg::LEN_W'(1);
    end else if (data_len_q > hce_pkg::LEN_W'(hce_pkg::MAX_DATA_BITS)) begin
      len_eff = hce_pkg::LEN_W'(hce_pkg::MAX_DATA_BITS);
    end else begin
      len_eff = data_len_q;
    end
  end

  assign par_cnt   = hce_pkg::parity_count(len_eff);
  assign total_len = len_eff + hce_pkg::LEN_W'(par_cnt);
  assign data_mask = ~({hce_pkg::DATA_W{1'b1}} << len_eff);
  assign data_used = data_q & data_mask;

  // scatter data bits: the n-th non-parity position from the bottom holds data bit n
  logic [hce_pkg::CW_W-1:0] cw_data;

  for (genvar p = 1; p <= hce_pkg::CW_W; p++) begin : g_pos
    if (hce_pkg::is_pow2(p)) begin : g_par
      assign cw_data[p-1] = 1'b0;
    end else begin : g_dat
      assign cw_data[p-1] = data_used[p-1-$clog2(p)];
    end
  end

  // even parity per check bit; unused check bits come out zero
  logic [hce_pkg::NUM_PAR-1:0] par;
  logic [hce_pkg::CW_W-1:0]    cw_par;

  always_comb begin
    cw_par = cw_data;
    for (int k = 0; k < hce_pkg::NUM_PAR; k++) begin
      par[k] = ^(cw_data & hce_pkg::par_mask(k));
      cw_par[(1 << k) - 1] = par[k];
    end
  end

  // error injection on one in-range position
  logic                     inject_hit;
  logic [hce_pkg::CW_W-1:0] inject_vec;
  hce_pkg::result_t         res_d;
  hce_pkg::result_t         res_q;

  assign inject_hit = inject_en_q && (inject_pos_q != '0) && (inject_pos_q <= total_len);
  assign inject_vec = inject_hit ?
                      (hce_pkg::CW_W'(1) << (inject_pos_q - hce_pkg::LEN_W'(1))) : '0;

  always_comb begin
    res_d.codeword     = cw_par ^ inject_vec;
    res_d.parity_count = par_cnt;
    res_d.codeword_len = total_len;
  end

  // output result register
  always_ff @(posedge clk_i) begin
    if (out_free && in_valid_q) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tdata_o = hce_pkg::M_TDATA_W'(res_q);

endmodule
